>>> rtl/core/spectral_brightness_ratio_defines.svh
// Assertion macros shared by the spectral brightness ratio RTL.
`ifndef SPECTRAL_BRIGHTNESS_RATIO_DEFINES_SVH
`define SPECTRAL_BRIGHTNESS_RATIO_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SBR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SBR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sbr_pkg.sv
// Package with constants, types and FSM encoding for the spectral brightness ratio block.
`default_nettype none
package sbr_pkg;

  localparam int MAG_BITS     = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_BINS_DEF = 4096;
  localparam int CUT_W        = 12;
  localparam int ACC_W        = 44;
  localparam int BRIGHT_W     = FRAC_BITS + 1;
  localparam int CNT_W        = 16;
  localparam int IN_DATA_W    = ((MAG_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W    = BRIGHT_W + 1 + 2 * CNT_W;
  localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int STEP_W       = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_LOAD,
    ST_DIVIDE,
    ST_STORE
  } sbr_state_e;

  typedef struct packed {
    logic bin_take;
    logic div_load;
    logic div_step;
    logic result_load;
  } sbr_cmd_t;

  typedef struct packed {
    logic out_stall;
  } sbr_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/spectral_brightness_ratio.sv
// Top level of the spectral brightness ratio block.
`default_nettype none
// Takes one magnitude bin per cycle while a frame streams in; each bin is squared
// and summed into total and high band energy (bins at or above cutoff_bin, plus
// the last bin). After the last bin transfer the block holds s_tready low while
// a pipeline drain state, a load state, a restoring divider producing one
// quotient bit per cycle, and a store state run; the store waits while the
// previous result still sits unread in the output register. Results hold
// brightness = high/total in Q1.16 (zero energy gives 0), a peak flag, and
// saturating peak and frame counts. cutoff_bin must be written through the cfg
// port only while no frame is in progress; the block itself does not enforce it.
module spectral_brightness_ratio #(
  parameter int MAX_BINS = sbr_pkg::MAX_BINS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sbr_pkg::CUT_W-1:0]     cfg_data_i,    // cutoff_bin
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire logic [sbr_pkg::IN_DATA_W-1:0] s_tdata_i,     // magnitude
  input  wire logic                          s_tlast_i,
  input  wire logic                          s_tuser_i,     // sequence_start
  output logic                               m_tvalid_o,
  input  wire logic                          m_tready_i,
  // brightness, peak, peak_count, frame_count, zero pad
  output logic [sbr_pkg::OUT_DATA_W-1:0]     m_tdata_o
);
  import sbr_pkg::*;

  sbr_cmd_t cmd;
  sbr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tlast_i  (s_tlast_i),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  sbr_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_tdata_i),
    .s_tlast_i   (s_tlast_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

>>> rtl/core/sbr_ctrl.sv
// Controller FSM: bin intake, drain, divide sequencing and result store.
`default_nettype none
`include "spectral_brightness_ratio_defines.svh"
module sbr_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_tvalid_i,
  input  wire logic           s_tlast_i,
  output logic                s_tready_o,
  output sbr_pkg::sbr_cmd_t   cmd_o,
  input  wire sbr_pkg::sbr_sts_t sts_i
);
  import sbr_pkg::*;

  sbr_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_ACCUM: begin
        s_tready_o     = 1'b1;
        cmd_o.bin_take = s_tvalid_i;
        if (s_tvalid_i && s_tlast_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(FRAC_BITS - 1)) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        if (!sts_i.out_stall) begin
          cmd_o.result_load = 1'b1;
          state_d           = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  `SBR_ASSERT_NEXT(a_last_drains, clk_i, rst_ni,
                   s_tvalid_i && s_tready_o && s_tlast_i, state_q == ST_DRAIN,
                   "last bin transfer did not start the drain")
  `SBR_ASSERT_NOW(a_store_no_stall, clk_i, rst_ni,
                  cmd_o.result_load, !sts_i.out_stall,
                  "result stored while output register is blocked")
  `SBR_ASSERT_NOW(a_step_bound, clk_i, rst_ni,
                  cmd_o.div_step, step_q < STEP_W'(FRAC_BITS),
                  "divide ran past its bit count")

endmodule
`default_nettype wire

>>> rtl/core/sbr_datapath.sv
// Datapath: squaring, saturating energy accumulators, restoring divider and result register.
`default_nettype none
`include "spectral_brightness_ratio_defines.svh"
module sbr_datapath #(
  parameter int MAX_BINS = sbr_pkg::MAX_BINS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [sbr_pkg::CUT_W-1:0]    cfg_data_i,
  input  wire logic [sbr_pkg::IN_DATA_W-1:0] s_tdata_i,
  input  wire logic                         s_tlast_i,
  input  wire logic                         s_tuser_i,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic [sbr_pkg::OUT_DATA_W-1:0]    m_tdata_o,
  input  wire sbr_pkg::sbr_cmd_t            cmd_i,
  output sbr_pkg::sbr_sts_t                 sts_o
);
  import sbr_pkg::*;

  localparam int IDX_W  = $clog2(MAX_BINS);
  localparam int CMP_W  = (IDX_W > CUT_W) ? IDX_W : CUT_W;
  localparam int SQ_W   = 2 * MAG_BITS;
  localparam int PK_W   = BRIGHT_W + 2;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_BINS - 1);

  logic [CUT_W-1:0]     cutoff_q;
  logic [IDX_W-1:0]     bin_idx_q, bin_idx_d;
  logic                 sq_vld_q;
  logic [SQ_W-1:0]      sq_q;
  logic                 hi_sel_q;
  logic [ACC_W-1:0]     total_q, total_d, high_q, high_d;
  logic                 have_prev_q, have_prev_d;
  logic [BRIGHT_W-1:0]  prev_q;
  logic [CNT_W-1:0]     peaks_q, peaks_d, frames_q, frames_d;
  logic [ACC_W-1:0]     rem_q, den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic                 zero_q, full_q;
  logic                 out_vld_q;
  logic [BRIGHT_W-1:0]  out_bright_q;
  logic                 out_peak_q;
  logic [CNT_W-1:0]     out_peaks_q, out_frames_q;

  logic [MAG_BITS-1:0]  mag;
  logic                 hi_sel;
  logic [ACC_W:0]       total_sum, high_sum, rem_sh, rem_sub;
  logic                 rem_ge;
  logic [BRIGHT_W-1:0]  bright;
  logic                 peak;

  assign mag    = s_tdata_i[MAG_BITS-1:0];
  assign hi_sel = (CMP_W'(bin_idx_q) >= CMP_W'(cutoff_q)) || s_tlast_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= '0;
    end else if (cfg_valid_i) begin
      cutoff_q <= cfg_data_i;
    end
  end

  // square stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= cmd_i.bin_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_take) begin
      sq_q     <= SQ_W'(mag) * SQ_W'(mag);
      hi_sel_q <= hi_sel;
    end
  end

  always_comb begin
    bin_idx_d = bin_idx_q;
    if (cmd_i.bin_take) begin
      if (s_tlast_i) begin
        bin_idx_d = '0;
      end else if (bin_idx_q != IDX_MAX) begin
        bin_idx_d = bin_idx_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    have_prev_d = have_prev_q;
    if (cmd_i.result_load) begin
      have_prev_d = 1'b1;
    end else if (cmd_i.bin_take && (bin_idx_q == '0) && s_tuser_i) begin
      have_prev_d = 1'b0;
    end
  end

  // saturating accumulate
  assign total_sum = (ACC_W + 1)'(total_q) + (ACC_W + 1)'(sq_q);
  assign high_sum  = (ACC_W + 1)'(high_q) + (ACC_W + 1)'(sq_q);

  always_comb begin
    total_d = total_q;
    high_d  = high_q;
    if (cmd_i.div_load) begin
      total_d = '0;
      high_d  = '0;
    end else if (sq_vld_q) begin
      total_d = total_sum[ACC_W] ? '1 : total_sum[ACC_W-1:0];
      if (hi_sel_q) begin
        high_d = high_sum[ACC_W] ? '1 : high_sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_idx_q   <= '0;
      total_q     <= '0;
      high_q      <= '0;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      peaks_q     <= '0;
      frames_q    <= '0;
    end else begin
      bin_idx_q   <= bin_idx_d;
      total_q     <= total_d;
      high_q      <= high_d;
      have_prev_q <= have_prev_d;
      if (cmd_i.result_load) begin
        prev_q   <= bright;
        peaks_q  <= peaks_d;
        frames_q <= frames_d;
      end
    end
  end

  // restoring divider, one quotient bit per step
  assign rem_sh  = {rem_q, 1'b0};
  assign rem_ge  = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q  <= high_q;
      den_q  <= total_q;
      quo_q  <= '0;
      zero_q <= (total_q == '0);
      full_q <= (high_q >= total_q);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
    end
  end

  always_comb begin
    if (zero_q) begin
      bright = '0;
    end else if (full_q) begin
      bright = BRIGHT_W'(1) << FRAC_BITS;
    end else begin
      bright = {1'b0, quo_q};
    end
  end

  assign peak = have_prev_q &&
                (PK_W'({bright, 1'b0}) > (PK_W'(prev_q) + PK_W'({prev_q, 1'b0})));

  always_comb begin
    peaks_d  = peaks_q;
    frames_d = frames_q;
    if (peak && (peaks_q != '1)) begin
      peaks_d = peaks_q + CNT_W'(1);
    end
    if (frames_q != '1) begin
      frames_d = frames_q + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_vld_q <= 1'b1;
    end else if (m_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_bright_q <= bright;
      out_peak_q   <= peak;
      out_peaks_q  <= peaks_d;
      out_frames_q <= frames_d;
    end
  end

  assign sts_o.out_stall = out_vld_q && !m_tready_i;
  assign m_tvalid_o      = out_vld_q;
  assign m_tdata_o       = OUT_DATA_W'({out_frames_q, out_peaks_q, out_peak_q, out_bright_q});

  `SBR_ASSERT_NOW(a_high_le_total, clk_i, rst_ni,
                  1'b1, high_q <= total_q,
                  "high band energy exceeds total energy")
  `SBR_ASSERT_NEXT(a_load_clears, clk_i, rst_ni,
                   cmd_i.div_load, (total_q == '0) && (high_q == '0),
                   "accumulators not cleared when divide starts")
  `SBR_ASSERT_NOW(a_peaks_le_frames, clk_i, rst_ni,
                  1'b1, peaks_q <= frames_q,
                  "peak count exceeds frame count")

endmodule
`default_nettype wire
